// ===== src/dci_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dci_pkg: shared constants, types and tables of the calibration interpolator
// Holds table geometry, fixed-point widths, opcodes and the default curve.
// ----------------------------------------------------------------------------
package dci_pkg;

    // table geometry and voltage format
    localparam int CHANNELS  = 4;
    localparam int POINTS    = 11;
    localparam int VOLT_MIN  = -3;
    localparam int FRAC_BITS = 12;

    localparam int CODE_W  = 16;
    localparam int VOLT_W  = 16;
    localparam int DEPTH   = CHANNELS * POINTS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PT_W    = $clog2(POINTS);
    localparam int SHIFT_W = 24;
    localparam int DIFF_W  = CODE_W + 1;
    localparam int PROD_W  = DIFF_W + FRAC_BITS + 1;
    localparam int NUM_W   = PROD_W + 1;

    // voltage limits in fixed point
    localparam logic signed [SHIFT_W-1:0] VMIN_Q =
        SHIFT_W'(VOLT_MIN * (2 ** FRAC_BITS));
    localparam logic signed [SHIFT_W-1:0] VMAX_Q =
        SHIFT_W'((VOLT_MIN + POINTS - 1) * (2 ** FRAC_BITS));
    localparam logic [NUM_W-1:0] HALF_Q = NUM_W'(2 ** (FRAC_BITS - 1));

    // default curve, points beyond it repeat full scale
    localparam int DEFAULT_COUNT = 11;
    localparam logic [CODE_W-1:0] DEFAULT_CURVE [DEFAULT_COUNT] = '{
        16'd4890, 16'd11443, 16'd17997, 16'd24551, 16'd31104, 16'd37658,
        16'd44211, 16'd50765, 16'd57318, 16'd63871, 16'd65535
    };
    localparam logic [CODE_W-1:0] CODE_MAX = 16'd65535;

    // command codes on the input word
    typedef enum logic [1:0] {
        ACT_CONVERT = 2'd0,
        ACT_READ    = 2'd1,
        ACT_WRITE   = 2'd2,
        ACT_NOP     = 2'd3
    } action_t;

    // what the pipeline does with a word
    typedef enum logic [1:0] {
        OP_ZERO,
        OP_POINT,
        OP_INTERP,
        OP_WRITE
    } op_kind_t;

    // decoded word, stage one to the table
    typedef struct packed {
        op_kind_t              kind;
        logic [ADDR_W-1:0]     addr_a;
        logic [ADDR_W-1:0]     addr_b;
        logic [PT_W-1:0]       pt_a;
        logic [PT_W-1:0]       pt_b;
        logic [FRAC_BITS-1:0]  frac;
        logic [CODE_W-1:0]     wdata;
    } dec_word_t;

    // neighbouring points, table to the interpolator
    typedef struct packed {
        op_kind_t              kind;
        logic [CODE_W-1:0]     lower;
        logic signed [DIFF_W-1:0] diff;
        logic [FRAC_BITS-1:0]  frac;
    } pair_word_t;

    // reset value of a point
    function automatic logic [CODE_W-1:0] default_point(input logic [PT_W-1:0] p);
        logic [CODE_W-1:0] v;
        v = CODE_MAX;
        if (32'(p) < DEFAULT_COUNT)
        begin
            v = DEFAULT_CURVE[p];
        end
        return v;
    endfunction

endpackage

// ===== src/dci_cmd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dci_cmd_if: command channel
// Carries convert, read and write words with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dci_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [2:0]         channel;
    logic signed [15:0] volts;
    logic [3:0]         point_num;
    logic [15:0]        point_value;

    modport source (output valid, action, channel, volts, point_num, point_value,
                    input ready);
    modport sink   (input valid, action, channel, volts, point_num, point_value,
                    output ready);
endinterface

// ===== src/dci_code_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dci_code_if: result channel
// Carries one DAC code word per command with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dci_code_if;
    logic        valid;
    logic        ready;
    logic [15:0] dac_code;

    modport source (output valid, dac_code, input ready);
    modport sink   (input valid, dac_code, output ready);
endinterface

// ===== src/dci_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dci_decode: command decode stage
// Checks channel and point, clamps the voltage and forms table addresses.
// ----------------------------------------------------------------------------
module dci_decode (
    input  logic                clk,
    input  logic                rst_n,
    dci_cmd_if.sink             cmd,
    output logic                dec_valid,
    input  logic                dec_ready,
    output dci_pkg::dec_word_t  dec_word
);
    import dci_pkg::*;

    logic                      valid_reg;
    logic                      valid_next;
    dec_word_t                 word_reg;
    dec_word_t                 word_next;
    logic signed [SHIFT_W-1:0] volts_ext;
    logic signed [SHIFT_W-1:0] shifted;
    logic                      ch_ok;
    logic                      pt_ok;
    logic                      accept;

    assign cmd.ready = !valid_reg || dec_ready;
    assign accept    = cmd.valid && cmd.ready;

    // voltage relative to the first point
    assign volts_ext = {{(SHIFT_W-VOLT_W){cmd.volts[VOLT_W-1]}}, cmd.volts};
    assign shifted   = volts_ext - VMIN_Q;
    assign ch_ok     = 32'(cmd.channel) < CHANNELS;
    assign pt_ok     = 32'(cmd.point_num) < POINTS;

    // decode of one command word
    always_comb
    begin
        word_next       = '0;
        word_next.kind  = OP_ZERO;
        word_next.frac  = shifted[FRAC_BITS-1:0];
        word_next.wdata = cmd.point_value;
        case (action_t'(cmd.action))
            ACT_CONVERT:
            begin
                if (ch_ok)
                begin
                    if (volts_ext <= VMIN_Q)
                    begin
                        word_next.kind = OP_POINT;
                        word_next.pt_a = '0;
                    end
                    else if (volts_ext >= VMAX_Q)
                    begin
                        word_next.kind = OP_POINT;
                        word_next.pt_a = PT_W'(POINTS - 1);
                    end
                    else
                    begin
                        word_next.kind = OP_INTERP;
                        word_next.pt_a = shifted[PT_W+FRAC_BITS-1:FRAC_BITS];
                        word_next.pt_b = shifted[PT_W+FRAC_BITS-1:FRAC_BITS] + 1'b1;
                    end
                end
            end
            ACT_READ:
            begin
                if (ch_ok && pt_ok)
                begin
                    word_next.kind = OP_POINT;
                    word_next.pt_a = cmd.point_num[PT_W-1:0];
                end
            end
            ACT_WRITE:
            begin
                if (ch_ok && pt_ok)
                begin
                    word_next.kind = OP_WRITE;
                    word_next.pt_a = cmd.point_num[PT_W-1:0];
                end
            end
            default:
            begin
                word_next.kind = OP_ZERO;
            end
        endcase
        word_next.addr_a = ADDR_W'(32'(cmd.channel) * POINTS + 32'(word_next.pt_a));
        word_next.addr_b = ADDR_W'(32'(cmd.channel) * POINTS + 32'(word_next.pt_b));
    end

    // stage valid
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (dec_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

    assign dec_valid = valid_reg;
    assign dec_word  = word_reg;

    // writes only ever target a real table entry
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && word_reg.kind == OP_WRITE) |-> (32'(word_reg.addr_a) < DEPTH))
        else $error("write word addresses beyond the table");

    // a stalled decode word keeps its payload
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !dec_ready) |=> (valid_reg && $stable(word_reg)))
        else $error("decode word changed while stalled");

endmodule

// ===== src/dci_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dci_table: calibration table stage
// Two-read-port point memory with per-entry valid bits over the default curve.
// ----------------------------------------------------------------------------
module dci_table (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                dec_valid,
    output logic                dec_ready,
    input  dci_pkg::dec_word_t  dec_word,
    output logic                pair_valid,
    input  logic                pair_ready,
    output dci_pkg::pair_word_t pair_word
);
    import dci_pkg::*;

    logic [CODE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  written_reg;
    logic              valid_reg;
    logic              valid_next;
    logic              adv;
    logic              wr_en;

    logic [CODE_W-1:0]    rd_a_reg;
    logic [CODE_W-1:0]    rd_b_reg;
    logic                 ok_a_reg;
    logic                 ok_b_reg;
    logic [CODE_W-1:0]    def_a_reg;
    logic [CODE_W-1:0]    def_b_reg;
    op_kind_t             kind_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [CODE_W-1:0]    lower;
    logic [CODE_W-1:0]    upper;

    assign dec_ready = !valid_reg || pair_ready;
    assign adv       = dec_valid && dec_ready;
    assign wr_en     = adv && dec_word.kind == OP_WRITE;

    // point memory, write and both reads in program order
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (wr_en)
            begin
                mem[dec_word.addr_a] <= dec_word.wdata;
            end
            rd_a_reg  <= mem[dec_word.addr_a];
            rd_b_reg  <= mem[dec_word.addr_b];
            ok_a_reg  <= written_reg[dec_word.addr_a];
            ok_b_reg  <= written_reg[dec_word.addr_b];
            def_a_reg <= default_point(dec_word.pt_a);
            def_b_reg <= default_point(dec_word.pt_b);
            kind_reg  <= dec_word.kind;
            frac_reg  <= dec_word.frac;
        end
    end

    // entries written since reset, others read as the default curve
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            written_reg[dec_word.addr_a] <= 1'b1;
        end
    end

    // stage valid
    always_comb
    begin
        valid_next = valid_reg;
        if (adv)
        begin
            valid_next = 1'b1;
        end
        else if (pair_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // pick stored or default points and take their difference
    assign lower = ok_a_reg ? rd_a_reg : def_a_reg;
    assign upper = ok_b_reg ? rd_b_reg : def_b_reg;

    always_comb
    begin
        pair_word.kind  = kind_reg;
        pair_word.lower = lower;
        pair_word.diff  = $signed({1'b0, upper}) - $signed({1'b0, lower});
        pair_word.frac  = frac_reg;
    end

    assign pair_valid = valid_reg;

    // a write marks its entry as loaded
    a_write_marks: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> written_reg[$past(dec_word.addr_a)])
        else $error("written entry not marked");

    // loaded entries never fall back to the default
    a_marks_stay: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((written_reg & $past(written_reg)) == $past(written_reg)))
        else $error("written mark lost");

endmodule

// ===== src/dci_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dci_interp: interpolation stages
// Multiplies the step by the fraction, rounds half up and saturates the code.
// ----------------------------------------------------------------------------
module dci_interp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pair_valid,
    output logic                pair_ready,
    input  dci_pkg::pair_word_t pair_word,
    dci_code_if.source          result
);
    import dci_pkg::*;

    // stage three: operands
    logic       s3_valid_reg;
    logic       s3_valid_next;
    pair_word_t s3_reg;
    logic       s3_ready;
    logic       s3_adv;

    // stage four: product
    logic                     s4_valid_reg;
    logic                     s4_valid_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic [CODE_W-1:0]        lower_reg;
    op_kind_t                 kind_reg;
    logic                     s4_ready;
    logic                     s4_adv;

    // output word
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [CODE_W-1:0]       code_reg;
    logic [CODE_W-1:0]       code_next;
    logic signed [NUM_W-1:0] num;
    logic [CODE_W-1:0]       interp_code;

    assign pair_ready = !s3_valid_reg || s3_ready;
    assign s3_adv     = pair_valid && pair_ready;
    assign s3_ready   = !s4_valid_reg || s4_ready;
    assign s4_adv     = s3_valid_reg && s3_ready;
    assign s4_ready   = !out_valid_reg || result.ready;

    // valid bits of the three stages
    always_comb
    begin
        s3_valid_next  = s3_valid_reg;
        s4_valid_next  = s4_valid_reg;
        out_valid_next = out_valid_reg;
        if (s3_adv)
        begin
            s3_valid_next = 1'b1;
        end
        else if (s3_ready)
        begin
            s3_valid_next = 1'b0;
        end
        if (s4_adv)
        begin
            s4_valid_next = 1'b1;
        end
        else if (s4_ready)
        begin
            s4_valid_next = 1'b0;
        end
        if (s4_valid_reg && s4_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg  <= s3_valid_next;
            s4_valid_reg  <= s4_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // operand register
    always_ff @(posedge clk)
    begin
        if (s3_adv)
        begin
            s3_reg <= pair_word;
        end
    end

    // step times fraction
    always_ff @(posedge clk)
    begin
        if (s4_adv)
        begin
            prod_reg  <= PROD_W'(s3_reg.diff * $signed({1'b0, s3_reg.frac}));
            lower_reg <= s3_reg.lower;
            kind_reg  <= s3_reg.kind;
        end
    end

    // round half up and saturate
    assign num = $signed({{(NUM_W-CODE_W-FRAC_BITS){1'b0}}, lower_reg, {FRAC_BITS{1'b0}}})
               + $signed({{(NUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg})
               + $signed(HALF_Q);

    always_comb
    begin
        if (num[NUM_W-1])
        begin
            interp_code = '0;
        end
        else if (|num[NUM_W-2:FRAC_BITS+CODE_W])
        begin
            interp_code = CODE_MAX;
        end
        else
        begin
            interp_code = num[FRAC_BITS+CODE_W-1:FRAC_BITS];
        end
    end

    // result selection by word kind
    always_comb
    begin
        case (kind_reg)
            OP_INTERP: code_next = interp_code;
            OP_POINT:  code_next = lower_reg;
            default:   code_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s4_valid_reg && s4_ready)
        begin
            code_reg <= code_next;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.dac_code = code_reg;

    // words without a code come out as zero
    a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && s4_ready && (kind_reg == OP_ZERO || kind_reg == OP_WRITE))
        |=> (code_reg == '0))
        else $error("zero word gave a nonzero code");

    // a stalled operand word holds while the product stage is full
    a_s3_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && !s3_ready) |=> (s3_valid_reg && $stable(s3_reg)))
        else $error("operand word changed while stalled");

endmodule

// ===== src/dac_calibration_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dac_calibration_interpolator: per-channel DAC calibration lookup
// Piecewise-linear voltage to DAC code conversion with a writable point table.
// ----------------------------------------------------------------------------
// Every command word gives exactly one result word, in order. The block takes
// one word per clock when the result side is not stalling. The decode register
// loads on acceptance, then come table read, operand register, multiply, and
// round and saturate into the output register. The rate is set by the point
// memory, which reads both neighbouring points of a channel in the same cycle,
// and by the single step-times-fraction multiplier. Writes and reads pass the
// memory in order, so a read straight after a write sees the new point. Reset
// restores the default curve at once through per-entry valid bits; there is no
// clearing pass.
// Backpressure on the result side stalls the whole pipeline without loss.
module dac_calibration_interpolator (
    input  logic       clk,
    input  logic       rst_n,
    dci_cmd_if.sink    cmd,
    dci_code_if.source result
);
    import dci_pkg::*;

    logic       dec_valid;
    logic       dec_ready;
    dec_word_t  dec_word;
    logic       pair_valid;
    logic       pair_ready;
    pair_word_t pair_word;

    // command decode
    dci_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .dec_valid (dec_valid),
        .dec_ready (dec_ready),
        .dec_word  (dec_word)
    );

    // point memory
    dci_table u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .dec_valid  (dec_valid),
        .dec_ready  (dec_ready),
        .dec_word   (dec_word),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair_word  (pair_word)
    );

    // interpolation and output
    dci_interp u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_valid (pair_valid),
        .pair_ready (pair_ready),
        .pair_word  (pair_word),
        .result     (result)
    );

endmodule

// ===== tb/sv/dci_code_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dci_code_checker: result checker of the calibration interpolator
// Watches the command and result channels and keeps a shadow calibration
// table. Each accepted command word gives one expected DAC code, which is
// compared in order with the result words as they are accepted.
// ----------------------------------------------------------------------------
module dci_code_checker (
    input  logic clk,
    input  logic rst_n,
    dci_cmd_if   cmd,
    dci_code_if  result,
    input  logic end_of_test,
    output int   failures,
    output int   outstanding,
    output int   words_checked
);
    import dci_pkg::*;

    localparam int SCALE = 1 << FRAC_BITS;
    localparam int FACTORY_COUNT = 11;
    localparam logic [15:0] FACTORY_CURVE [FACTORY_COUNT] = '{
        16'd4890, 16'd11443, 16'd17997, 16'd24551, 16'd31104, 16'd37658,
        16'd44211, 16'd50765, 16'd57318, 16'd63871, 16'd65535
    };

    // shadow of the point table and the codes still owed by the block
    logic [15:0] cal_points [CHANNELS * POINTS];
    logic [15:0] pending_codes [$];

    initial
    begin
        failures = 0;
    end

    // one line per mismatch, printing capped, counting not
    task automatic report_mismatch(input string what);
        if (failures < 50)
        begin
            $display("[%0t] ERROR: %s", $time, what);
        end
        failures++;
    endtask

    // piecewise-linear lookup with clamping at both ends, rounding half up
    function automatic logic [15:0] interpolate(input int ch, input logic signed [15:0] volts);
        int     base;
        longint v;
        longint lo_q;
        longint hi_q;
        longint shifted;
        longint seg;
        longint frac;
        longint lower;
        longint upper;
        longint num;
        longint code;
        base = ch * POINTS;
        v = volts;
        lo_q = longint'(VOLT_MIN) * SCALE;
        hi_q = longint'(VOLT_MIN + POINTS - 1) * SCALE;
        if (v <= lo_q)
        begin
            return cal_points[base];
        end
        if (v >= hi_q)
        begin
            return cal_points[base + POINTS - 1];
        end
        shifted = v - lo_q;
        seg = shifted / SCALE;
        frac = shifted % SCALE;
        lower = cal_points[base + int'(seg)];
        upper = cal_points[base + int'(seg) + 1];
        num = lower * SCALE + (upper - lower) * frac + SCALE / 2;
        if (num <= 0)
        begin
            return 16'd0;
        end
        code = num / SCALE;
        if (code > 65535)
        begin
            code = 65535;
        end
        return 16'(code);
    endfunction

    // expected code of one command word, writes land in the shadow table
    function automatic logic [15:0] apply_word(input logic [1:0] act, input logic [2:0] ch,
                                               input logic signed [15:0] volts,
                                               input logic [3:0] pt, input logic [15:0] value);
        logic [15:0] code;
        logic        ch_ok;
        logic        pt_ok;
        code = 16'd0;
        ch_ok = int'(ch) < CHANNELS;
        pt_ok = int'(pt) < POINTS;
        case (action_t'(act))
            ACT_CONVERT:
            begin
                if (ch_ok)
                begin
                    code = interpolate(int'(ch), volts);
                end
            end
            ACT_READ:
            begin
                if (ch_ok && pt_ok)
                begin
                    code = cal_points[int'(ch) * POINTS + int'(pt)];
                end
            end
            ACT_WRITE:
            begin
                if (ch_ok && pt_ok)
                begin
                    cal_points[int'(ch) * POINTS + int'(pt)] = value;
                end
            end
            default:
            begin
                code = 16'd0;
            end
        endcase
        return code;
    endfunction

    // predict on command acceptance, compare on result acceptance
    always @(posedge clk or negedge rst_n)
    begin
        int          p;
        logic [15:0] want;
        if (!rst_n)
        begin
            for (p = 0; p < CHANNELS * POINTS; p++)
            begin
                cal_points[p] = ((p % POINTS) < FACTORY_COUNT) ?
                                FACTORY_CURVE[p % POINTS] : 16'hFFFF;
            end
            pending_codes.delete();
            outstanding <= 0;
            words_checked <= 0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                pending_codes.push_back(apply_word(cmd.action, cmd.channel, cmd.volts,
                                                   cmd.point_num, cmd.point_value));
            end
            if (result.valid && result.ready)
            begin
                if (pending_codes.size() == 0)
                begin
                    report_mismatch($sformatf("result word 0x%04h with no command pending",
                                              result.dac_code));
                end
                else
                begin
                    want = pending_codes.pop_front();
                    if (result.dac_code !== want)
                    begin
                        report_mismatch($sformatf("dac_code 0x%04h, expected 0x%04h (word %0d)",
                                                  result.dac_code, want, words_checked));
                    end
                    words_checked <= words_checked + 1;
                end
            end
            outstanding <= pending_codes.size();
        end
    end

    // anything still owed at the end is lost
    always @(posedge end_of_test)
    begin
        if (pending_codes.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected result words never arrived",
                                      pending_codes.size()));
        end
    end

endmodule

// ===== tb/sv/tb_dac_calibration_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dac_calibration_interpolator: testbench of the calibration interpolator
// Drives directed and random convert, read, write and no-op words through
// phases of sender idling and receiver stalls; the checker beside the block
// predicts every DAC code and the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_dac_calibration_interpolator;
    import dci_pkg::*;

    localparam int SCALE = 1 << FRAC_BITS;
    localparam int V_LO  = VOLT_MIN * SCALE;
    localparam int V_HI  = (VOLT_MIN + POINTS - 1) * SCALE;

    typedef struct {
        action_t            action;
        logic [2:0]         channel;
        logic signed [15:0] volts;
        logic [3:0]         point_num;
        logic [15:0]        point_value;
    } cmd_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic end_of_test;
    int   send_idle_pct;
    int   stall_pct;
    int   sent_by_action [4];
    int   failures;
    int   outstanding;
    int   words_checked;

    dci_cmd_if  cmd_ch ();
    dci_code_if code_ch ();

    dac_calibration_interpolator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .result (code_ch)
    );

    dci_code_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd_ch),
        .result        (code_ch),
        .end_of_test   (end_of_test),
        .failures      (failures),
        .outstanding   (outstanding),
        .words_checked (words_checked)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side stalls at random
    always @(posedge clk)
    begin
        code_ch.ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
    end

    // hard stop for a hung block
    initial
    begin
        #2_000_000;
        $display("timeout: result words still owed after the time limit");
        $display("Mismatches found");
        $finish;
    end

    function automatic cmd_word_t make_word(input action_t act, input int ch, input int volts,
                                            input int pt, input int value);
        cmd_word_t w;
        w.action = act;
        w.channel = 3'(ch);
        w.volts = 16'(volts);
        w.point_num = 4'(pt);
        w.point_value = 16'(value);
        return w;
    endfunction

    // mostly well-formed traffic on valid channels, some out-of-range and no-op words
    function automatic cmd_word_t random_word();
        cmd_word_t w;
        int        roll;
        int        pick;
        w.action = ACT_CONVERT;
        w.channel = 3'($urandom);
        w.volts = 16'($urandom);
        w.point_num = 4'($urandom);
        w.point_value = 16'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 40)
        begin
            // convert inside the table range and just past its ends
            w.channel = 3'($urandom_range(0, CHANNELS - 1));
            w.volts = 16'(V_LO - 64 + int'($urandom_range(0, V_HI - V_LO + 128)));
        end
        else if (roll < 50)
        begin
            // convert with any channel and any voltage
            w.action = ACT_CONVERT;
        end
        else if (roll < 55)
        begin
            // convert on or next to a whole volt
            w.channel = 3'($urandom_range(0, CHANNELS - 1));
            w.volts = 16'((VOLT_MIN + int'($urandom_range(0, POINTS - 1))) * SCALE
                          + int'($urandom_range(0, 2)) - 1);
        end
        else if (roll < 70)
        begin
            // load a point, zero and full-scale codes now and then
            w.action = ACT_WRITE;
            w.channel = 3'($urandom_range(0, CHANNELS - 1));
            w.point_num = 4'($urandom_range(0, POINTS - 1));
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                w.point_value = 16'd0;
            end
            else if (pick == 1)
            begin
                w.point_value = 16'hFFFF;
            end
        end
        else if (roll < 85)
        begin
            w.action = ACT_READ;
            w.channel = 3'($urandom_range(0, CHANNELS - 1));
            w.point_num = 4'($urandom_range(0, POINTS - 1));
        end
        else if (roll < 95)
        begin
            // table access with any channel and index
            w.action = ($urandom_range(0, 1) == 0) ? ACT_READ : ACT_WRITE;
        end
        else
        begin
            w.action = ACT_NOP;
        end
        return w;
    endfunction

    // present one word, idling first at random, hold until accepted
    task automatic send_word(input cmd_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.action <= w.action;
        cmd_ch.channel <= w.channel;
        cmd_ch.volts <= w.volts;
        cmd_ch.point_num <= w.point_num;
        cmd_ch.point_value <= w.point_value;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        sent_by_action[w.action]++;
    endtask

    // stop sending until every owed result word has come back or the limit is reached
    task automatic wait_drained(input int limit);
        int waited;
        waited = 0;
        cmd_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < limit);
    endtask

    // one phase of random traffic, sender idling and receiver stalls as given, with a drain halfway
    task automatic run_random(input int count, input int idle_pct, input int stall);
        int n;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        for (n = 0; n < count; n++)
        begin
            if (n == count / 2)
            begin
                wait_drained(1000);
            end
            send_word(random_word());
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.action <= ACT_NOP;
        cmd_ch.channel <= 3'd0;
        cmd_ch.volts <= 16'sd0;
        cmd_ch.point_num <= 4'd0;
        cmd_ch.point_value <= 16'd0;
        end_of_test = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // default curve at both ends and clamping at the field extremes
        send_word(make_word(ACT_READ, 0, 0, 0, 0));
        send_word(make_word(ACT_READ, CHANNELS - 1, 0, POINTS - 1, 0));
        send_word(make_word(ACT_CONVERT, 0, -32768, 0, 0));
        send_word(make_word(ACT_CONVERT, 0, 32767, 0, 0));
        send_word(make_word(ACT_CONVERT, 1, V_LO, 0, 0));
        send_word(make_word(ACT_CONVERT, 1, V_LO + 1, 0, 0));
        send_word(make_word(ACT_CONVERT, 2, V_HI, 0, 0));
        send_word(make_word(ACT_CONVERT, 2, V_HI - 1, 0, 0));
        send_word(make_word(ACT_CONVERT, 3, 0, 0, 0));
        send_word(make_word(ACT_CONVERT, 0, SCALE / 2, 0, 0));
        // tiny step to hit rounding of an exact half
        send_word(make_word(ACT_WRITE, 1, 0, 4, 0));
        send_word(make_word(ACT_WRITE, 1, 0, 5, 1));
        send_word(make_word(ACT_CONVERT, 1, (4 + VOLT_MIN) * SCALE + SCALE / 2, 0, 0));
        // falling segment, then read back of a point written just before
        send_word(make_word(ACT_WRITE, 1, 0, 6, 65535));
        send_word(make_word(ACT_WRITE, 1, 0, 7, 0));
        send_word(make_word(ACT_CONVERT, 1, (6 + VOLT_MIN) * SCALE + 1000, 0, 0));
        send_word(make_word(ACT_READ, 1, 0, 6, 0));
        // out-of-range channel and point, no-op
        send_word(make_word(ACT_WRITE, 4, 0, 0, 1234));
        send_word(make_word(ACT_READ, 4, 0, 0, 0));
        send_word(make_word(ACT_CONVERT, 7, 0, 0, 0));
        send_word(make_word(ACT_WRITE, 0, 0, POINTS, 777));
        send_word(make_word(ACT_READ, 0, 0, 15, 0));
        send_word(make_word(ACT_NOP, 0, -1, 0, 65535));
        // full-scale first point seen through low clamping
        send_word(make_word(ACT_WRITE, 2, 0, 0, 65535));
        send_word(make_word(ACT_CONVERT, 2, -32768, 0, 0));

        run_random(460, 0, 0);
        run_random(460, 46, 0);
        run_random(460, 0, 46);
        run_random(460, 27, 27);

        wait_drained(2000);
        repeat (10) @(posedge clk);
        end_of_test = 1'b1;
        #1;

        $display("covered %0d command words: %0d convert, %0d read, %0d write, %0d no-op",
                 sent_by_action[0] + sent_by_action[1] + sent_by_action[2] + sent_by_action[3],
                 sent_by_action[ACT_CONVERT], sent_by_action[ACT_READ],
                 sent_by_action[ACT_WRITE], sent_by_action[ACT_NOP]);
        $display("%0d result words checked across free-running, idle, stall and mixed phases",
                 words_checked);
        if (failures == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/dci_pkg.sv
src/dci_cmd_if.sv
src/dci_code_if.sv
src/dci_decode.sv
src/dci_table.sv
src/dci_interp.sv
src/dac_calibration_interpolator.sv
tb/sv/dci_code_checker.sv
tb/sv/tb_dac_calibration_interpolator.sv
